// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bres_pkg.sv =====
// shared types and constants of the line pixel generator
package bres_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ERR_BITS        = COORD_BITS + 4;
    localparam int ERR_MAX         = 2 ** (ERR_BITS - 1) - 1;
    localparam int MAX_RUN         = 64;
    localparam int RUN_BITS        = $clog2(MAX_RUN + 1);
    localparam int WIDTH_BITS      = 13;
    localparam int OFF_BITS        = 24;
    localparam int COLOR_BITS      = 8;
    localparam int LANES           = 4;
    localparam int WORD_BITS       = COLOR_BITS * LANES;
    localparam int LANE_BITS       = 2;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = WIDTH_BITS;
    localparam int S_DATA_BITS     = 4 * COORD_BITS + WORD_BITS;
    localparam int M_DATA_BITS     = OFF_BITS + WORD_BITS;
    localparam int ROW_WIDTH_RESET = 640;

    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic signed [COORD_BITS+1:0] delta2_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW_WIDTH  = 3'd0,
        REG_RED_LANE   = 3'd1,
        REG_GREEN_LANE = 3'd2,
        REG_BLUE_LANE  = 3'd3,
        REG_ALPHA_LANE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LANE_BITS-1:0] alpha;
        logic [LANE_BITS-1:0] blue;
        logic [LANE_BITS-1:0] green;
        logic [LANE_BITS-1:0] red;
    } lane_cfg_t;

    localparam lane_cfg_t LANE_RESET = '{alpha: 2'd3, blue: 2'd2, green: 2'd1, red: 2'd0};

endpackage

// ===== rtl/core/bres_lane_pack.sv =====
// places the four color bytes at their configured lanes of the pixel word
module bres_lane_pack
    import bres_pkg::*;
(
    input  lane_cfg_t               lanes,
    input  logic [COLOR_BITS-1:0]   red,
    input  logic [COLOR_BITS-1:0]   green,
    input  logic [COLOR_BITS-1:0]   blue,
    input  logic [COLOR_BITS-1:0]   alpha,
    output logic [WORD_BITS-1:0]    word
);

    always_comb
    begin
        word = '0;
        for (int i = 0; i < LANES; i++)
        begin
            // later channels win on colliding lanes
            if (lanes.red == LANE_BITS'(i))
            begin
                word[i*COLOR_BITS +: COLOR_BITS] = red;
            end
            if (lanes.green == LANE_BITS'(i))
            begin
                word[i*COLOR_BITS +: COLOR_BITS] = green;
            end
            if (lanes.blue == LANE_BITS'(i))
            begin
                word[i*COLOR_BITS +: COLOR_BITS] = blue;
            end
            if (lanes.alpha == LANE_BITS'(i))
            begin
                word[i*COLOR_BITS +: COLOR_BITS] = alpha;
            end
        end
    end

endmodule

// ===== rtl/core/bres_step_unit.sv =====
// one bresenham step: saturating error update and incremental pixel offset
module bres_step_unit
    import bres_pkg::*;
(
    input  err_t                    err,
    input  delta2_t                 dy2,
    input  delta2_t                 dx2,
    input  logic [OFF_BITS-1:0]     off,
    input  logic [WIDTH_BITS-1:0]   row_width,
    output err_t                    err_next,
    output logic [OFF_BITS-1:0]     off_next
);

    localparam logic signed [ERR_BITS:0] SUM_HI = (ERR_BITS + 1)'(ERR_MAX);
    localparam logic signed [ERR_BITS:0] SUM_LO = -SUM_HI;

    logic                       step_up;
    logic signed [ERR_BITS:0]   sum;
    logic signed [ERR_BITS:0]   dx_term;

    always_comb
    begin
        step_up = err > err_t'(0);
        dx_term = step_up ? (ERR_BITS + 1)'(dx2) : '0;
        sum     = (ERR_BITS + 1)'(err) + (ERR_BITS + 1)'(dy2) - dx_term;
        if (sum > SUM_HI)
        begin
            err_next = err_t'(SUM_HI);
        end
        else if (sum < SUM_LO)
        begin
            err_next = err_t'(SUM_LO);
        end
        else
        begin
            err_next = err_t'(sum);
        end
        // y step moves one row down the surface
        off_next = off + OFF_BITS'(1) + (step_up ? OFF_BITS'(row_width) : '0);
    end

endmodule

// ===== rtl/core/bresenham_line_pixel_generator_core.sv =====
// top level: config registers, segment sequencer and output register
// a taken segment passes ST_SETUP, then ST_RUN puts its pixels in the output register
// throughput: one pixel per cycle while m_tready is high, set by the single step unit
// a segment yields min(end_x - start_x, 64) pixels (one for equal points); the next one
// is taken only after its last pixel is issued; others with end_x <= start_x are dropped
// reset (rst_n low, async): row_width 640, lanes red 0 green 1 blue 2 alpha 3, no pending beat
module bresenham_line_pixel_generator_core
    import bres_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    // start_x, start_y, end_x, end_y, red, green, blue, alpha
    input  logic [S_DATA_BITS-1:0]      s_tdata,

    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pixel_offset, pixel_word
    output logic [M_DATA_BITS-1:0]      m_tdata,
    // last_pixel
    output logic                        m_tlast,
    // cut_short
    output logic                        m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t                         state_reg, state_next;
    logic [WIDTH_BITS-1:0]          row_width_reg, row_width_next;
    lane_cfg_t                      lanes_reg, lanes_next;
    logic [COORD_BITS-1:0]          x0_reg, x0_next;
    logic [COORD_BITS-1:0]          y0_reg, y0_next;
    delta2_t                        dx2_reg, dx2_next;
    delta2_t                        dy2_reg, dy2_next;
    err_t                           err_reg, err_next;
    logic [OFF_BITS-1:0]            off_reg, off_next;
    logic [WORD_BITS-1:0]           color_reg, color_next;
    logic [RUN_BITS-1:0]            left_reg, left_next;
    logic                           cut_reg, cut_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [OFF_BITS-1:0]            m_off_reg, m_off_next;
    logic [WORD_BITS-1:0]           m_word_reg, m_word_next;
    logic                           m_tlast_reg, m_tlast_next;
    logic                           m_tuser_reg, m_tuser_next;

    logic [COORD_BITS-1:0]          start_x, start_y, end_x, end_y;
    logic [COLOR_BITS-1:0]          red, green, blue, alpha;
    logic signed [COORD_BITS:0]     dx, dy;
    delta2_t                        dx2, dy2;
    logic [COORD_BITS-1:0]          span;
    logic [WORD_BITS-1:0]           packed_word;
    err_t                           step_err;
    logic [OFF_BITS-1:0]            step_off;
    logic [WIDTH_BITS+COORD_BITS-1:0] row_base;
    logic                           in_beat;
    logic                           out_free;

    assign start_x = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign start_y = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign end_x   = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign end_y   = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign red     = s_tdata[4*COORD_BITS + 0*COLOR_BITS +: COLOR_BITS];
    assign green   = s_tdata[4*COORD_BITS + 1*COLOR_BITS +: COLOR_BITS];
    assign blue    = s_tdata[4*COORD_BITS + 2*COLOR_BITS +: COLOR_BITS];
    assign alpha   = s_tdata[4*COORD_BITS + 3*COLOR_BITS +: COLOR_BITS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_word_reg, m_off_reg};
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    bres_lane_pack u_pack (
        .lanes (lanes_reg),
        .red   (red),
        .green (green),
        .blue  (blue),
        .alpha (alpha),
        .word  (packed_word)
    );

    bres_step_unit u_step (
        .err       (err_reg),
        .dy2       (dy2_reg),
        .dx2       (dx2_reg),
        .off       (off_reg),
        .row_width (row_width_reg),
        .err_next  (step_err),
        .off_next  (step_off)
    );

    always_comb
    begin
        dx       = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
        dy       = signed'({1'b0, end_y}) - signed'({1'b0, start_y});
        dx2      = {dx, 1'b0};
        dy2      = {dy, 1'b0};
        span     = end_x - start_x;
        row_base = row_width_reg * y0_reg;
        in_beat  = s_tvalid && s_tready;
        out_free = !m_tvalid_reg || m_tready;

        state_next     = state_reg;
        row_width_next = row_width_reg;
        lanes_next     = lanes_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        dx2_next       = dx2_reg;
        dy2_next       = dy2_reg;
        err_next       = err_reg;
        off_next       = off_reg;
        color_next     = color_reg;
        left_next      = left_reg;
        cut_next       = cut_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_off_next     = m_off_reg;
        m_word_next    = m_word_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:  row_width_next = cfg_data;
                REG_RED_LANE:   lanes_next.red = cfg_data[LANE_BITS-1:0];
                REG_GREEN_LANE: lanes_next.green = cfg_data[LANE_BITS-1:0];
                REG_BLUE_LANE:  lanes_next.blue = cfg_data[LANE_BITS-1:0];
                REG_ALPHA_LANE: lanes_next.alpha = cfg_data[LANE_BITS-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    x0_next    = start_x;
                    y0_next    = start_y;
                    dx2_next   = dx2;
                    dy2_next   = dy2;
                    err_next   = err_t'(dy2) - err_t'(dx);
                    color_next = packed_word;
                    if (start_x == end_x && start_y == end_y)
                    begin
                        left_next  = RUN_BITS'(1);
                        cut_next   = 1'b0;
                        state_next = ST_SETUP;
                    end
                    else if (end_x > start_x)
                    begin
                        if (span > COORD_BITS'(MAX_RUN))
                        begin
                            left_next = RUN_BITS'(MAX_RUN);
                            cut_next  = 1'b1;
                        end
                        else
                        begin
                            left_next = RUN_BITS'(span);
                            cut_next  = 1'b0;
                        end
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                off_next   = OFF_BITS'(row_base) + OFF_BITS'(x0_reg);
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_off_next    = off_reg;
                    m_word_next   = color_reg;
                    m_tlast_next  = (left_reg == RUN_BITS'(1));
                    m_tuser_next  = (left_reg == RUN_BITS'(1)) && cut_reg;
                    err_next      = step_err;
                    off_next      = step_off;
                    left_next     = left_reg - RUN_BITS'(1);
                    if (left_reg == RUN_BITS'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_width_reg <= WIDTH_BITS'(ROW_WIDTH_RESET);
            lanes_reg     <= LANE_RESET;
            x0_reg        <= '0;
            y0_reg        <= '0;
            dx2_reg       <= '0;
            dy2_reg       <= '0;
            err_reg       <= '0;
            off_reg       <= '0;
            color_reg     <= '0;
            left_reg      <= '0;
            cut_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_off_reg     <= '0;
            m_word_reg    <= '0;
            m_tlast_reg   <= 1'b0;
            m_tuser_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_width_reg <= row_width_next;
            lanes_reg     <= lanes_next;
            x0_reg        <= x0_next;
            y0_reg        <= y0_next;
            dx2_reg       <= dx2_next;
            dy2_reg       <= dy2_next;
            err_reg       <= err_next;
            off_reg       <= off_next;
            color_reg     <= color_next;
            left_reg      <= left_next;
            cut_reg       <= cut_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_off_reg     <= m_off_next;
            m_word_reg    <= m_word_next;
            m_tlast_reg   <= m_tlast_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

endmodule

// ===== rtl/core/bres_checker.sv =====
// port-level checks for the line pixel generator, bound to the top level
`include "assert_macros.svh"

module bres_checker
    import bres_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tready,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_DATA_BITS-1:0]  m_tdata,
    input  logic                    m_tlast,
    input  logic                    m_tuser
);

    // a stalled beat keeps its payload
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled pixel beat changed")

    // cut short flag only on the final pixel of a segment
    `ASSERT_SAME(a_cut_last, clk, rst_n, m_tvalid && m_tuser, m_tlast, "cut_short without last_pixel")

    // no new segment while a segment still has pixels to send
    `ASSERT_SAME(a_busy, clk, rst_n, m_tvalid && !m_tlast, !s_tready, "segment taken mid-run")

    // a taken non-final pixel is followed by the next one in the next cycle
    `ASSERT_NEXT(a_rate, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a segment run")

endmodule

bind bresenham_line_pixel_generator_core bres_checker u_bres_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the line pixel generator core: directed, lane, back-pressure, random
module testbench;
    import bres_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_SLACK = 8;

    typedef struct packed {
        logic [COLOR_BITS-1:0] alpha;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
        logic [COORD_BITS-1:0] end_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] start_x;
    } segment_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [OFF_BITS-1:0]  offset;
    } pixel_beat_t;

    typedef struct {
        logic [OFF_BITS-1:0]  offset;
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic                 cut;
    } pixel_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]   m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;

    // shadow of the register file
    logic [WIDTH_BITS-1:0]    row_width_copy = WIDTH_BITS'(ROW_WIDTH_RESET);
    lane_cfg_t                lane_copy = LANE_RESET;

    pixel_t                   pending_pixels[$];
    int                       send_gap_pct = 0;
    int                       rx_idle_pct = 0;
    int                       rx_hold_cycles = 0;
    int                       quiet_cycles = 0;
    int                       mismatch_count = 0;
    int                       pixels_checked = 0;
    int                       segments_taken = 0;
    int                       settings_applied = 0;

    bresenham_line_pixel_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint clamp_err(input longint v);
        if (v > ERR_MAX)
            return ERR_MAX;
        if (v < -ERR_MAX)
            return -ERR_MAX;
        return v;
    endfunction

    // walks one segment and queues the pixels it should produce
    function automatic void trace_segment(input segment_t seg);
        logic [WORD_BITS-1:0] word;
        pixel_t               px;
        int                   dx;
        int                   dy;
        int                   x;
        int                   y;
        int                   run;
        bit                   cut;
        longint               err;
        word = '0;
        word[lane_copy.red*8 +: 8]   = seg.red;
        word[lane_copy.green*8 +: 8] = seg.green;
        word[lane_copy.blue*8 +: 8]  = seg.blue;
        word[lane_copy.alpha*8 +: 8] = seg.alpha;
        dx = int'(seg.end_x) - int'(seg.start_x);
        dy = int'(seg.end_y) - int'(seg.start_y);
        x = int'(seg.start_x);
        y = int'(seg.start_y);
        err = clamp_err(2 * dy - dx);
        px.word = word;
        if (seg.start_x == seg.end_x && seg.start_y == seg.end_y)
        begin
            px.offset = OFF_BITS'(row_width_copy * y + x);
            px.last = 1'b1;
            px.cut = 1'b0;
            pending_pixels.push_back(px);
        end
        else if (seg.end_x > seg.start_x)
        begin
            cut = dx > MAX_RUN;
            run = cut ? MAX_RUN : dx;
            for (int k = run; k > 0; k--)
            begin
                px.offset = OFF_BITS'(row_width_copy * y + x);
                px.last = (k == 1);
                px.cut = (k == 1) && cut;
                pending_pixels.push_back(px);
                if (err > 0)
                begin
                    y++;
                    err = clamp_err(err + 2 * dy - 2 * dx);
                end
                else
                    err = clamp_err(err + 2 * dy);
                x = (x + 1) & ((1 << COORD_BITS) - 1);
            end
        end
    endfunction

    // register writes, segment predictions and pixel checks, all sampled at the edge
    always @(posedge clk)
    begin : monitor
        pixel_t      want;
        pixel_beat_t got;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:  row_width_copy = cfg_data;
                REG_RED_LANE:   lane_copy.red = cfg_data[LANE_BITS-1:0];
                REG_GREEN_LANE: lane_copy.green = cfg_data[LANE_BITS-1:0];
                REG_BLUE_LANE:  lane_copy.blue = cfg_data[LANE_BITS-1:0];
                REG_ALPHA_LANE: lane_copy.alpha = cfg_data[LANE_BITS-1:0];
                default: ;
            endcase
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            segments_taken++;
            trace_segment(segment_t'(s_tdata));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel beat: pixel_offset %0h pixel_word %0h",
                       got.offset, got.word);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got.offset !== want.offset)
                begin
                    $error("pixel_offset expected %0h actual %0h", want.offset, got.offset);
                    mismatch_count++;
                end
                if (got.word !== want.word)
                begin
                    $error("pixel_word expected %0h actual %0h", want.word, got.word);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_pixel expected %0b actual %0b", want.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.cut)
                begin
                    $error("cut_short expected %0b actual %0b", want.cut, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // pixel sink: random stalls plus an optional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // valid stays high after the beat so a following call can reuse it in the same step
    task automatic send_segment(input segment_t seg);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= seg;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic stream_idle();
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic drain_pixels();
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic apply_config(input int rw, input int rl, input int gl, input int bl,
                                input int al);
        drain_pixels();
        write_reg(REG_ROW_WIDTH, CFG_DATA_BITS'(rw));
        write_reg(REG_RED_LANE, CFG_DATA_BITS'(rl));
        write_reg(REG_GREEN_LANE, CFG_DATA_BITS'(gl));
        write_reg(REG_BLUE_LANE, CFG_DATA_BITS'(bl));
        write_reg(REG_ALPHA_LANE, CFG_DATA_BITS'(al));
        cfg_valid <= 1'b0;
        settings_applied++;
        @(posedge clk);
    endtask

    function automatic segment_t seg_of(input int x0, input int y0, input int x1, input int y1,
                                        input logic [WORD_BITS-1:0] rgba);
        segment_t seg;
        seg.start_x = COORD_BITS'(x0);
        seg.start_y = COORD_BITS'(y0);
        seg.end_x = COORD_BITS'(x1);
        seg.end_y = COORD_BITS'(y1);
        {seg.alpha, seg.blue, seg.green, seg.red} = rgba;
        return seg;
    endfunction

    function automatic segment_t random_segment();
        logic [95:0] bits;
        segment_t    seg;
        int          pick;
        int          span;
        int          rise;
        bits = {$urandom, $urandom, $urandom};
        seg = bits[S_DATA_BITS-1:0];
        pick = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
        if (pick < 65)
        begin
            rise = $urandom_range(0, span);
            seg.start_x = COORD_BITS'($urandom_range(0, 4095 - span));
            seg.end_x = COORD_BITS'(int'(seg.start_x) + span);
            seg.start_y = COORD_BITS'($urandom_range(0, 4095 - rise));
            seg.end_y = COORD_BITS'(int'(seg.start_y) + rise);
        end
        else if (pick < 80)
        begin
            // steep or falling
            seg.start_x = COORD_BITS'($urandom_range(0, 4095 - span));
            seg.end_x = COORD_BITS'(int'(seg.start_x) + span);
        end
        else if (pick < 88)
        begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
        end
        else if (pick < 94)
            seg.end_x = COORD_BITS'($urandom_range(0, seg.start_x));
        return seg;
    endfunction

    task automatic test_directed();
        send_segment(seg_of(0, 0, 0, 0, 32'h0000_0000));
        send_segment(seg_of(4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
        send_segment(seg_of(0, 0, 1, 0, 32'h5AA5_5AA5));
        send_segment(seg_of(100, 5, 50, 9, 32'h1122_3344));
        send_segment(seg_of(7, 1, 7, 30, 32'h5566_7788));
        send_segment(seg_of(10, 10, 20, 20, 32'h0102_0408));
        send_segment(seg_of(0, 0, 40, 13, 32'h1020_4080));
        send_segment(seg_of(0, 4095, 64, 4095, 32'hA5A5_A5A5));
        send_segment(seg_of(0, 0, 65, 3, 32'h8000_0001));
        send_segment(seg_of(0, 0, 4095, 4095, 32'hDEAD_BEEF));
        send_segment(seg_of(100, 0, 110, 4095, 32'hCAFE_F00D));
        send_segment(seg_of(100, 4095, 160, 0, 32'h0F0F_F0F0));
        send_segment(seg_of(4031, 100, 4095, 120, 32'h7F80_01FE));
        send_segment(seg_of(4094, 0, 4095, 4095, 32'hFF00_FF00));
        send_segment(seg_of(5, 4095, 6, 0, 32'h00FF_00FF));
        stream_idle();
    endtask

    task automatic test_lane_settings();
        apply_config(1, 3, 2, 1, 0);
        send_segment(seg_of(0, 0, 10, 4, 32'h4433_2211));
        send_segment(seg_of(4095, 4095, 4095, 4095, 32'h8877_6655));
        stream_idle();
        // every channel on one lane: alpha wins, the rest read zero
        apply_config(4096, 0, 0, 0, 0);
        send_segment(seg_of(4000, 4000, 4064, 4095, 32'hAABB_CCDD));
        send_segment(seg_of(0, 4095, 0, 4095, 32'h1234_5678));
        stream_idle();
        // widest row so the offset wraps
        apply_config(8191, 1, 1, 3, 3);
        send_segment(seg_of(4000, 4030, 4064, 4095, 32'h9ABC_DEF0));
        send_segment(seg_of(0, 4095, 30, 4095, 32'h0F1E_2D3C));
        stream_idle();
        apply_config(0, 2, 3, 0, 1);
        send_segment(seg_of(50, 200, 70, 210, 32'h6655_4433));
        stream_idle();
        apply_config(ROW_WIDTH_RESET, 0, 1, 2, 3);
        send_segment(seg_of(1, 2, 3, 4, 32'hC3C3_3C3C));
        stream_idle();
    endtask

    task automatic test_backpressure();
        drain_pixels();
        rx_hold_cycles = 300;
        send_segment(seg_of(200, 300, 230, 310, 32'h1111_2222));
        send_segment(seg_of(400, 10, 435, 40, 32'h3333_4444));
        send_segment(seg_of(900, 900, 925, 900, 32'h5555_6666));
        send_segment(seg_of(17, 17, 17, 17, 32'h7777_8888));
        stream_idle();
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int productive);
        segment_t seg;
        int       made;
        apply_config($urandom_range(1, 4096), $urandom_range(3), $urandom_range(3),
                     $urandom_range(3), $urandom_range(3));
        send_gap_pct = gap_pct;
        rx_idle_pct = stall_pct;
        made = 0;
        while (made < productive)
        begin
            seg = random_segment();
            if ((seg.start_x == seg.end_x && seg.start_y == seg.end_y)
                || seg.end_x > seg.start_x)
                made++;
            send_segment(seg);
        end
        stream_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct = 19;
        rx_idle_pct = 49;
        test_directed();
        test_lane_settings();
        test_backpressure();
        test_random_traffic(19, 49, 25);
        test_random_traffic(49, 19, 25);
        test_random_traffic(0, 0, 25);
        drain_pixels();
        $display("run covered %0d segments, %0d pixel beats checked, %0d register settings",
                 segments_taken, pixels_checked, settings_applied);
        $display("idle mixes: sender-heavy, receiver-heavy, none; one long sink hold-off");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
